>>> hdl/tpa_pkg.sv
// Shared types and constants for the trackball pulse accumulator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tpa_pkg;

   localparam int DEF_COUNT_WIDTH = 16;
   localparam int DEF_TIME_WIDTH  = 32;

   localparam int DIR_COUNT  = 4;
   localparam int DIR_UP     = 0;
   localparam int DIR_DOWN   = 1;
   localparam int DIR_LEFT   = 2;
   localparam int DIR_RIGHT  = 3;

   localparam int DELTA_W    = 16;
   localparam int PPP_W      = 5;
   localparam int TICKS_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;

   localparam logic [PPP_W-1:0]   PPP_RESET      = 5'd1;
   localparam logic [TICKS_W-1:0] TIMEOUT_RESET  = 16'd100;
   localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 16'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PIXELS   = 2'd0,
      REG_TIMEOUT  = 2'd1,
      REG_DEBOUNCE = 2'd2
   } tpa_reg_type;

   typedef struct packed {
      logic [TICKS_W-1:0] debounce_ticks;
      logic [TICKS_W-1:0] pulse_timeout_ticks;
      logic [PPP_W-1:0]   pulse_gain;
   } tpa_cfg_type;

   // held in the input register; levels ordered up, down, left, right from bit 0
   typedef struct packed {
      logic                 poll;
      logic                 button_level;
      logic [DIR_COUNT-1:0] levels;
   } tpa_item_type;

   // delta_x sits in the lowest bits
   typedef struct packed {
      logic                      changed;
      logic                      btn_down;
      logic signed [DELTA_W-1:0] delta_y;
      logic signed [DELTA_W-1:0] delta_x;
   } tpa_result_type;

endpackage

>>> hdl/trackball_pulse_accumulator_core.sv
// Top level of the trackball pulse accumulator: stream ports, config registers,
// input register. Depends on tpa_pkg, tpa_pulse_counter and tpa_poll_unit.
// An accepted poll item waits in the input register; its result is then held in the output register.
// Throughput: one item per cycle; the input register stalls only while it holds
// a poll item, a result waits in the output register and the sink is not ready.
// Reset (synchronous): counts, times, deltas and button cleared, pins taken
// as idle high, registers at 1 / 100 / 50 pixels, timeout and debounce ticks.
`timescale 1ns / 1ps

module trackball_pulse_accumulator_core
   import tpa_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // up_level, down_level, left_level, right_level, button_level, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // delta_x[15:0], delta_y[31:16], debounced button, changed, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   tpa_cfg_type    cfg_ff;
   tpa_item_type   item_ff;
   logic           item_valid_ff;
   logic           advance;
   logic           fire;
   logic           clear;
   tpa_result_type result;

   logic [DIR_COUNT-1:0][COUNT_WIDTH-1:0] counts_now;
   logic [TIME_WIDTH-1:0]                 tick_now;
   logic [TIME_WIDTH-1:0]                 edge_stamp_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_gain          <= PPP_RESET;
         cfg_ff.pulse_timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PIXELS:   cfg_ff.pulse_gain          <= csr_wdata[PPP_W-1:0];
            REG_TIMEOUT:  cfg_ff.pulse_timeout_ticks <= csr_wdata[TICKS_W-1:0];
            REG_DEBOUNCE: cfg_ff.debounce_ticks      <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // tick-only items never wait on the result side
   assign advance    = !item_ff.poll || !rsp_tvalid || rsp_tready;
   assign fire       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         item_valid_ff <= 1'b1;
      end else if (fire) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.poll         <= req_tuser;
         item_ff.levels       <= req_tdata[DIR_COUNT-1:0];
         item_ff.button_level <= req_tdata[DIR_COUNT];
      end
   end

   tpa_pulse_counter #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_counter (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .levels         (item_ff.levels),
      .clear          (clear),
      .counts_now     (counts_now),
      .tick_now       (tick_now),
      .edge_stamp_now (edge_stamp_now)
   );

   tpa_poll_unit #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_poll (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .poll           (item_ff.poll),
      .button_level   (item_ff.button_level),
      .cfg            (cfg_ff),
      .counts_now     (counts_now),
      .tick_now       (tick_now),
      .edge_stamp_now (edge_stamp_now),
      .clear          (clear),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_result     (result)
   );

   assign rsp_tdata = {(RSP_TDATA_W - $bits(tpa_result_type))'(0), result};

endmodule

>>> hdl/tpa_pulse_counter.sv
// Tick counter, falling-edge detection and per-direction pulse counts.
// Depends on tpa_pkg.
`timescale 1ns / 1ps

module tpa_pulse_counter
   import tpa_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  logic [DIR_COUNT-1:0]                  levels,
   input  logic                                  clear,
   output logic [DIR_COUNT-1:0][COUNT_WIDTH-1:0] counts_now,
   output logic [TIME_WIDTH-1:0]                 tick_now,
   output logic [TIME_WIDTH-1:0]                 edge_stamp_now
);

   logic [DIR_COUNT-1:0]                  prev_ff;
   logic [DIR_COUNT-1:0][COUNT_WIDTH-1:0] counts_ff;
   logic [DIR_COUNT-1:0][COUNT_WIDTH-1:0] counts_in;
   logic [TIME_WIDTH-1:0]                 tick_ff;
   logic [TIME_WIDTH-1:0]                 tick_in;
   logic [TIME_WIDTH-1:0]                 edge_stamp_ff;
   logic [DIR_COUNT-1:0]                  falls;

   assign tick_in  = tick_ff + TIME_WIDTH'(1);
   assign tick_now = tick_in;
   assign falls    = prev_ff & ~levels;

   always_comb begin
      for (int i = 0; i < DIR_COUNT; i++) begin
         counts_now[i] = counts_ff[i] + COUNT_WIDTH'(falls[i]);
         counts_in[i]  = clear ? '0 : counts_now[i];
      end
   end

   // edges on this tick stamp the already advanced time
   assign edge_stamp_now = (|falls) ? tick_in : edge_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '1;
         counts_ff     <= '0;
         tick_ff       <= '0;
         edge_stamp_ff <= '0;
      end else if (fire) begin
         prev_ff       <= levels;
         counts_ff     <= counts_in;
         tick_ff       <= tick_in;
         edge_stamp_ff <= edge_stamp_now;
      end
   end

endmodule

>>> hdl/tpa_poll_unit.sv
// Poll handling: scaled net deltas, timeout, button debounce and result register.
// Depends on tpa_pkg; fed by tpa_pulse_counter.
`timescale 1ns / 1ps

module tpa_poll_unit
   import tpa_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  logic                                  poll,
   input  logic                                  button_level,
   input  tpa_cfg_type                           cfg,
   input  logic [DIR_COUNT-1:0][COUNT_WIDTH-1:0] counts_now,
   input  logic [TIME_WIDTH-1:0]                 tick_now,
   input  logic [TIME_WIDTH-1:0]                 edge_stamp_now,
   output logic                                  clear,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output tpa_result_type                        rsp_result
);

   localparam int EXT_W  = (COUNT_WIDTH > DELTA_W) ? COUNT_WIDTH : DELTA_W;
   localparam int PROD_W = EXT_W + PPP_W + 1;

   logic [COUNT_WIDTH-1:0]     diff_x, diff_y;
   logic signed [EXT_W-1:0]    ext_x, ext_y;
   logic signed [PPP_W:0]      scale;
   logic signed [PROD_W-1:0]   prod_x, prod_y;
   logic [DELTA_W-1:0]         dx, dy;
   logic                       moved;
   logic [TIME_WIDTH-1:0]      idle_time, button_time;
   logic                       timed_out, settled;
   logic                       pressed;
   logic                       load;

   logic [DELTA_W-1:0]         held_dx_ff, held_dx_in;
   logic [DELTA_W-1:0]         held_dy_ff, held_dy_in;
   logic                       stable_ff, stable_in;
   logic [TIME_WIDTH-1:0]      last_button_ff, last_button_in;
   logic                       changed;
   logic                       rsp_valid_ff;
   tpa_result_type             result_ff;

   // net counts wrap at the count width, then sign-extend and scale
   assign diff_x = counts_now[DIR_RIGHT] - counts_now[DIR_LEFT];
   assign diff_y = counts_now[DIR_DOWN]  - counts_now[DIR_UP];
   assign ext_x  = EXT_W'(signed'(diff_x));
   assign ext_y  = EXT_W'(signed'(diff_y));
   assign scale  = signed'({1'b0, cfg.pulse_gain});
   assign prod_x = ext_x * scale;
   assign prod_y = ext_y * scale;
   assign dx     = prod_x[DELTA_W-1:0];
   assign dy     = prod_y[DELTA_W-1:0];
   assign moved  = (dx != '0) || (dy != '0);

   assign idle_time   = tick_now - edge_stamp_now;
   assign timed_out   = idle_time > TIME_WIDTH'(cfg.pulse_timeout_ticks);
   assign button_time = tick_now - last_button_ff;
   assign settled     = button_time > TIME_WIDTH'(cfg.debounce_ticks);
   assign pressed     = ~button_level;

   assign load  = fire && poll;
   assign clear = poll && moved;

   always_comb begin
      held_dx_in     = held_dx_ff;
      held_dy_in     = held_dy_ff;
      stable_in      = stable_ff;
      last_button_in = last_button_ff;
      changed        = 1'b0;
      if (moved) begin
         held_dx_in = dx;
         held_dy_in = dy;
         changed    = 1'b1;
      end else if (timed_out && ((held_dx_ff != '0) || (held_dy_ff != '0))) begin
         held_dx_in = '0;
         held_dy_in = '0;
         changed    = 1'b1;
      end
      if (pressed != stable_ff) begin
         if (settled) begin
            last_button_in = tick_now;
            stable_in      = pressed;
            changed        = 1'b1;
         end
      end else begin
         last_button_in = tick_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_dx_ff     <= '0;
         held_dy_ff     <= '0;
         stable_ff      <= 1'b0;
         last_button_ff <= '0;
      end else if (load) begin
         held_dx_ff     <= held_dx_in;
         held_dy_ff     <= held_dy_in;
         stable_ff      <= stable_in;
         last_button_ff <= last_button_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff.delta_x  <= signed'(held_dx_in);
         result_ff.delta_y  <= signed'(held_dy_in);
         result_ff.btn_down <= stable_in;
         result_ff.changed  <= changed;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

>>> hdl/tpa_checker.sv
// Port-level checks for trackball_pulse_accumulator_core, bound to the top level.
// Depends on tpa_pkg.
`timescale 1ns / 1ps

module tpa_checker
   import tpa_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // no result comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   // input side stalls only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // two results in a row that differ must flag a change
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_tvalid && rsp_tready && $past(rsp_tvalid && rsp_tready)
      && (rsp_tdata[32:0] != $past(rsp_tdata[32:0])) |-> rsp_tdata[33])
      else $error("deltas or button changed without changed flag");

endmodule

bind trackball_pulse_accumulator_core tpa_checker u_tpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
